[rtl/core/pipt_pkg.sv]
`timescale 1ns / 1ps

package pipt_pkg;

  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic accept;
    logic clear;
    logic append;
    logic drop;
    logic rd_walk;
    logic rd_close;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;
    logic pipe_empty;
  } dp_sts_t;

endpackage

[rtl/core/pipt_ram.sv]
`timescale 1ns / 1ps

module pipt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/pipt_ctrl.sv]
`timescale 1ns / 1ps

module pipt_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [pipt_pkg::CMD_W-1:0] cmd_i,
  input  pipt_pkg::dp_sts_t        sts_i,
  output pipt_pkg::dp_cmd_t        dp_cmd_o,
  output logic                     busy_o,
  output logic                     done_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WALK  = 3'd1;
  localparam logic [2:0] ST_CLOSE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          dp_cmd_o.accept = 1'b1;
          state_d         = ST_RESP;
          case (cmd_i)
            pipt_pkg::CMD_CLEAR: begin
              dp_cmd_o.clear = 1'b1;
            end
            pipt_pkg::CMD_APPEND: begin
              dp_cmd_o.append = !sts_i.full;
              dp_cmd_o.drop   = sts_i.full;
            end
            pipt_pkg::CMD_QUERY: begin
              if (!sts_i.empty) begin
                state_d = ST_WALK;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_WALK: begin
        dp_cmd_o.rd_walk = 1'b1;
        if (sts_i.last) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        dp_cmd_o.rd_close = 1'b1;
        state_d           = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_RESP);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("block stayed busy after result");

  a_no_read_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!dp_cmd_o.rd_walk && !dp_cmd_o.rd_close && sts_i.pipe_empty))
    else $error("result shown while edge walk still running");

endmodule

[rtl/core/pipt_dp.sv]
`timescale 1ns / 1ps

module pipt_dp #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pipt_pkg::dp_cmd_t     cmd_i,
  input  logic [COORD_BITS-1:0] coord_x_i,
  input  logic [COORD_BITS-1:0] coord_y_i,
  output pipt_pkg::dp_sts_t     sts_o,
  output logic                  inside_res_o,
  output logic                  status_o
);

  localparam int C     = COORD_BITS;
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic [CNT_W-1:0] count_q;
  logic [AW-1:0]    rd_ptr_q;
  logic             parity_q, status_q;
  logic             vld0_q, first_q;
  logic             s1_act_q, s2_act_q, s3_act_q, s4_act_q;

  logic [C-1:0]     qx_q, qy_q, prev_x_q, prev_y_q;
  logic [C-1:0]     s1_xlo_q, s1_ylo_q, s1_xhi_q, s1_yhi_q;
  logic [C:0]       s2_a1_q, s2_b1_q, s2_a2_q, s2_b2_q;
  logic [C-1:0]     s3_ma1_q, s3_mb1_q, s3_ma2_q, s3_mb2_q;
  logic             s3_n1_q, s3_n2_q, s4_n1_q, s4_n2_q;
  logic [2*C-1:0]   s4_p1_q, s4_p2_q;

  logic [2*C-1:0]   rdata;
  logic [C-1:0]     cur_x, cur_y;
  logic             rd_en, edge_vld, up, down, lt;
  logic [AW-1:0]    raddr;
  logic [C:0]       neg_a1, neg_a2;

  assign rd_en = cmd_i.rd_walk || cmd_i.rd_close;
  assign raddr = cmd_i.rd_close ? '0 : rd_ptr_q;

  pipt_ram #(
    .WIDTH (2 * C),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({coord_x_i, coord_y_i}),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cur_x    = rdata[2*C-1:C];
  assign cur_y    = rdata[C-1:0];
  assign edge_vld = vld0_q && !first_q;
  assign up       = ($signed(prev_y_q) <= $signed(qy_q)) && ($signed(qy_q) < $signed(cur_y));
  assign down     = ($signed(cur_y) <= $signed(qy_q)) && ($signed(qy_q) < $signed(prev_y_q));

  assign neg_a1 = -s2_a1_q;
  assign neg_a2 = -s2_a2_q;

  always_comb begin
    if (s4_n1_q != s4_n2_q) begin
      lt = s4_n1_q;
    end else if (!s4_n1_q) begin
      lt = (s4_p1_q < s4_p2_q);
    end else begin
      lt = (s4_p1_q > s4_p2_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_ptr_q <= '0;
      parity_q <= 1'b0;
      status_q <= 1'b0;
      vld0_q   <= 1'b0;
      first_q  <= 1'b0;
      s1_act_q <= 1'b0;
      s2_act_q <= 1'b0;
      s3_act_q <= 1'b0;
      s4_act_q <= 1'b0;
    end else begin
      vld0_q   <= rd_en;
      s1_act_q <= edge_vld && (up || down);
      s2_act_q <= s1_act_q;
      s3_act_q <= s2_act_q;
      s4_act_q <= s3_act_q;
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.append) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.accept) begin
        rd_ptr_q <= '0;
        parity_q <= 1'b0;
        status_q <= cmd_i.drop;
        first_q  <= 1'b1;
      end else begin
        if (cmd_i.rd_walk) begin
          rd_ptr_q <= rd_ptr_q + AW'(1);
        end
        if (vld0_q) begin
          first_q <= 1'b0;
        end
        if (s4_act_q && lt) begin
          parity_q <= !parity_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      qx_q <= coord_x_i;
      qy_q <= coord_y_i;
    end
    if (vld0_q) begin
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
    end
    s1_xlo_q <= up ? prev_x_q : cur_x;
    s1_ylo_q <= up ? prev_y_q : cur_y;
    s1_xhi_q <= up ? cur_x : prev_x_q;
    s1_yhi_q <= up ? cur_y : prev_y_q;
    s2_a1_q  <= {qx_q[C-1], qx_q} - {s1_xlo_q[C-1], s1_xlo_q};
    s2_b1_q  <= {s1_yhi_q[C-1], s1_yhi_q} - {s1_ylo_q[C-1], s1_ylo_q};
    s2_a2_q  <= {s1_xhi_q[C-1], s1_xhi_q} - {s1_xlo_q[C-1], s1_xlo_q};
    s2_b2_q  <= {qy_q[C-1], qy_q} - {s1_ylo_q[C-1], s1_ylo_q};
    s3_ma1_q <= s2_a1_q[C] ? neg_a1[C-1:0] : s2_a1_q[C-1:0];
    s3_ma2_q <= s2_a2_q[C] ? neg_a2[C-1:0] : s2_a2_q[C-1:0];
    s3_mb1_q <= s2_b1_q[C-1:0];
    s3_mb2_q <= s2_b2_q[C-1:0];
    s3_n1_q  <= s2_a1_q[C];
    s3_n2_q  <= s2_a2_q[C] && (s2_b2_q != '0);
    s4_p1_q  <= (2*C)'(s3_ma1_q) * (2*C)'(s3_mb1_q);
    s4_p2_q  <= (2*C)'(s3_ma2_q) * (2*C)'(s3_mb2_q);
    s4_n1_q  <= s3_n1_q;
    s4_n2_q  <= s3_n2_q;
  end

  assign sts_o.empty      = (count_q == '0);
  assign sts_o.full       = (count_q == CNT_W'(MAX_VERTICES));
  assign sts_o.last       = ((CNT_W'(rd_ptr_q) + CNT_W'(1)) == count_q);
  assign sts_o.pipe_empty = !(vld0_q || s1_act_q || s2_act_q || s3_act_q || s4_act_q);

  assign inside_res_o = parity_q;
  assign status_o     = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond table depth");

  a_accept_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> sts_o.pipe_empty)
    else $error("item accepted while edge pipeline busy");

endmodule

[rtl/core/point_in_polygon_test_unit.sv]
`timescale 1ns / 1ps

// Ray-crossing point-in-polygon unit. Each item (cmd_i with coord_x_i/coord_y_i) clears the
// vertex table, appends one vertex, or queries one point; every item gives exactly one result,
// shown on inside_res_o/status_o for the single cycle that done_o is high. The receiver cannot
// stall: sample the result in that cycle. Clear, append and unused codes go from accept straight
// to the result state and back to idle. A query over n stored vertices reads the vertex RAM once
// per cycle (n reads plus one re-read of the first vertex to close the polygon), and then waits
// for the edge test pipeline to drain before it shows the result. status_o is high
// when an append hits a full table and is dropped. An empty polygon answers outside.
module point_in_polygon_test_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [pipt_pkg::CMD_W-1:0] cmd_i,
  input  logic [COORD_BITS-1:0]      coord_x_i,
  input  logic [COORD_BITS-1:0]      coord_y_i,
  output logic                       done_o,
  output logic                       inside_res_o,
  output logic                       status_o
);

  pipt_pkg::dp_cmd_t dp_cmd;
  pipt_pkg::dp_sts_t dp_sts;

  pipt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cmd_i    (cmd_i),
    .sts_i    (dp_sts),
    .dp_cmd_o (dp_cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  pipt_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .sts_o        (dp_sts),
    .inside_res_o (inside_res_o),
    .status_o     (status_o)
  );

endmodule
